[rtl/owtr_pkg.sv]
package owtr_pkg;

  // Delay counter width (conversion wait is masked to this many bits)
  localparam int WaitBits = 24;

  // Register indexes (taken from paddr[2])
  localparam logic RegTicksPerUnit = 1'b0;
  localparam logic RegConvWait     = 1'b1;

  // One-wire command bytes
  localparam logic [7:0] CmdSkipRom  = 8'hCC;
  localparam logic [7:0] CmdConvert  = 8'h44;
  localparam logic [7:0] CmdReadPad  = 8'hBE;

  // Slot and reset timing, in delay units
  localparam int RstPreUnits  = 12;
  localparam int RstLowUnits  = 80;
  localparam int RstWaitUnits = 10;
  localparam int RstPostUnits = 5;
  localparam int SlotUnits    = 5;

  // Transaction step: which byte was just handled
  localparam logic [2:0] StepSkipA    = 3'd0;
  localparam logic [2:0] StepConvert  = 3'd1;
  localparam logic [2:0] StepSkipB    = 3'd2;
  localparam logic [2:0] StepReadCmd  = 3'd3;
  localparam logic [2:0] StepLowByte  = 3'd4;
  localparam logic [2:0] StepHighByte = 3'd5;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_PRE   = 4'd1,
    PH_RST_LOW   = 4'd2,
    PH_RST_WAIT  = 4'd3,
    PH_RST_POST  = 4'd4,
    PH_WR_START  = 4'd5,
    PH_WR_BIT    = 4'd6,
    PH_WR_TAIL   = 4'd7,
    PH_RD_START  = 4'd8,
    PH_RD_SAMPLE = 4'd9,
    PH_RD_GAP    = 4'd10,
    PH_CONV      = 4'd11
  } phase_e;

  typedef struct packed {
    logic [15:0] ticks_per_unit;
    logic [23:0] conversion_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic               device_absent;
    logic signed [15:0] temperature;
    logic               done_res;
    logic               busy_res;
    logic               line_drive;
  } res_t;

endpackage

[rtl/owtr_cfg.sv]
module owtr_cfg
  import owtr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [15:0] tpu_q;
  logic [23:0] cwt_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= 16'd12;
      cwt_q <= 24'd1000000;
    end else if (wr_en) begin
      case (paddr[2])
        RegTicksPerUnit: tpu_q <= pwdata[15:0];
        RegConvWait:     cwt_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      RegTicksPerUnit: prdata = {16'd0, tpu_q};
      RegConvWait:     prdata = {8'd0, cwt_q};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o.ticks_per_unit        = tpu_q;
  assign cfg_o.conversion_wait_ticks = cwt_q;

endmodule

[rtl/owtr_core.sv]
module owtr_core
  import owtr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  logic start_req_i,
  input  logic wait_conversion_i,
  input  logic line_in_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  phase_e              ph_q, ph_d;
  logic [2:0]          step_q, step_d;
  logic [2:0]          bit_q, bit_d;
  logic [7:0]          sh_q, sh_d;
  logic [7:0]          low_q, low_d;
  logic [15:0]         uc_q, uc_d;
  logic [WaitBits-1:0] dc_q, dc_d;
  logic                wl_q, wl_d;
  logic                abs_q, abs_d;

  logic [15:0]         tpu_eff;
  logic [15:0]         uc_inc;
  logic                unit_hit;
  logic [15:0]         uc_nxt;
  logic [WaitBits-1:0] dc_dec;
  logic                unit_end;
  logic [WaitBits-1:0] conv_wait;
  logic [2:0]          bit_inc;

  // unit timer: one tick of a unit-timed phase
  assign tpu_eff   = (cfg_i.ticks_per_unit == 16'd0) ? 16'd1 : cfg_i.ticks_per_unit;
  assign uc_inc    = uc_q + 16'd1;
  assign unit_hit  = (uc_inc >= tpu_eff);
  assign uc_nxt    = unit_hit ? 16'd0 : uc_inc;
  assign dc_dec    = (unit_hit && (dc_q != '0)) ? dc_q - WaitBits'(1) : dc_q;
  assign unit_end  = (dc_dec == '0);
  assign conv_wait = WaitBits'(cfg_i.conversion_wait_ticks);
  assign bit_inc   = bit_q + 3'd1;

  // next state and result for the current item
  always_comb begin
    ph_d   = ph_q;
    step_d = step_q;
    bit_d  = bit_q;
    sh_d   = sh_q;
    low_d  = low_q;
    uc_d   = uc_q;
    dc_d   = dc_q;
    wl_d   = wl_q;
    abs_d  = abs_q;

    res_o.line_drive  = 1'b1;
    res_o.busy_res    = (ph_q != PH_IDLE);
    res_o.done_res    = 1'b0;
    res_o.temperature = '0;

    case (ph_q)
      PH_IDLE: begin
        if (start_req_i) begin
          wl_d   = wait_conversion_i;
          step_d = StepSkipA;
          ph_d   = PH_RST_PRE;
          dc_d   = WaitBits'(RstPreUnits);
          uc_d   = '0;
          res_o.busy_res = 1'b1;
        end
      end
      PH_RST_PRE: begin
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          ph_d = PH_RST_LOW;
          dc_d = WaitBits'(RstLowUnits);
          uc_d = '0;
        end
      end
      PH_RST_LOW: begin
        res_o.line_drive = 1'b0;
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          ph_d = PH_RST_WAIT;
          dc_d = WaitBits'(RstWaitUnits);
          uc_d = '0;
        end
      end
      PH_RST_WAIT: begin
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          // presence sample: high means nobody pulled the bus
          abs_d = line_in_i;
          ph_d  = PH_RST_POST;
          dc_d  = WaitBits'(RstPostUnits);
          uc_d  = '0;
        end
      end
      PH_RST_POST: begin
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          sh_d  = CmdSkipRom;
          bit_d = '0;
          ph_d  = PH_WR_START;
          dc_d  = '0;
          uc_d  = '0;
        end
      end
      PH_WR_START: begin
        res_o.line_drive = 1'b0;
        ph_d = PH_WR_BIT;
        dc_d = WaitBits'(SlotUnits);
        uc_d = '0;
      end
      PH_WR_BIT: begin
        res_o.line_drive = sh_q[0];
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          sh_d  = {1'b0, sh_q[7:1]};
          bit_d = bit_inc;
          ph_d  = (bit_inc == 3'd0) ? PH_WR_TAIL : PH_WR_START;
          dc_d  = (bit_inc == 3'd0) ? WaitBits'(SlotUnits) : '0;
          uc_d  = '0;
        end
      end
      PH_WR_TAIL: begin
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          uc_d = '0;
          case (step_q)
            StepSkipA: begin
              step_d = StepConvert;
              sh_d   = CmdConvert;
              bit_d  = '0;
              ph_d   = PH_WR_START;
              dc_d   = '0;
            end
            StepConvert: begin
              step_d = StepSkipB;
              if (wl_q && (conv_wait != '0)) begin
                ph_d = PH_CONV;
                dc_d = conv_wait;
              end else begin
                ph_d = PH_RST_PRE;
                dc_d = WaitBits'(RstPreUnits);
              end
            end
            StepSkipB: begin
              step_d = StepReadCmd;
              sh_d   = CmdReadPad;
              bit_d  = '0;
              ph_d   = PH_WR_START;
              dc_d   = '0;
            end
            StepReadCmd: begin
              step_d = StepLowByte;
              sh_d   = '0;
              bit_d  = '0;
              ph_d   = PH_RD_START;
              dc_d   = '0;
            end
            default: begin
              step_d = StepSkipA;
              ph_d   = PH_IDLE;
              dc_d   = '0;
            end
          endcase
        end
      end
      PH_RD_START: begin
        res_o.line_drive = 1'b0;
        ph_d = PH_RD_SAMPLE;
        dc_d = '0;
        uc_d = '0;
      end
      PH_RD_SAMPLE: begin
        // LSB first: shift in from the top
        sh_d = {line_in_i, sh_q[7:1]};
        ph_d = PH_RD_GAP;
        dc_d = WaitBits'(SlotUnits);
        uc_d = '0;
      end
      PH_RD_GAP: begin
        uc_d = uc_nxt;
        dc_d = dc_dec;
        if (unit_end) begin
          bit_d = bit_inc;
          dc_d  = '0;
          uc_d  = '0;
          if (bit_inc != 3'd0) begin
            ph_d = PH_RD_START;
          end else if (step_q == StepLowByte) begin
            low_d  = sh_q;
            step_d = StepHighByte;
            sh_d   = '0;
            bit_d  = '0;
            ph_d   = PH_RD_START;
          end else begin
            res_o.done_res    = 1'b1;
            res_o.temperature = {sh_q, low_q};
            step_d = StepSkipA;
            ph_d   = PH_IDLE;
          end
        end
      end
      PH_CONV: begin
        // conversion wait counts raw ticks
        dc_d = (dc_q != '0) ? dc_q - WaitBits'(1) : dc_q;
        if (dc_d == '0) begin
          ph_d = PH_RST_PRE;
          dc_d = WaitBits'(RstPreUnits);
          uc_d = '0;
        end
      end
      default: begin
        step_d = StepSkipA;
        ph_d   = PH_IDLE;
        dc_d   = '0;
        uc_d   = '0;
      end
    endcase

    res_o.device_absent = abs_d;
  end

  // state advances once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      step_q <= '0;
      bit_q  <= '0;
      sh_q   <= '0;
      low_q  <= '0;
      uc_q   <= '0;
      dc_q   <= '0;
      wl_q   <= 1'b0;
      abs_q  <= 1'b0;
    end else if (accept_i) begin
      ph_q   <= ph_d;
      step_q <= step_d;
      bit_q  <= bit_d;
      sh_q   <= sh_d;
      low_q  <= low_d;
      uc_q   <= uc_d;
      dc_q   <= dc_d;
      wl_q   <= wl_d;
      abs_q  <= abs_d;
    end
  end

endmodule

[rtl/owtr_out.sv]
module owtr_out
  import owtr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        res_i,
  input  logic        m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [23:0] m_axis_tdata,
  output logic        ready_o
);

  logic valid_q;
  res_t res_q;

  // free when empty or being drained this cycle
  assign ready_o = ~valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {4'd0, res_q};

endmodule

[rtl/one_wire_temperature_reader.sv]
// The result item for an input item is shown on m_axis in the cycle after it is accepted.
// One item per cycle unless stalled; an item is one bus tick, stepped by the phase register.
// A stalled result holds in the output register and blocks the input until it is taken.
// Reset (rst_ni low, asynchronous): idle phase, counters and bytes cleared,
// ticks_per_unit = 12, conversion_wait_ticks = 1000000, no result pending.
module one_wire_temperature_reader
  import owtr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] start_req, [1] wait_conversion, [2] line_in
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] line_drive, [1] busy_res, [2] done_res,
                                      // [18:3] temperature, [19] device_absent
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  res_t res;
  logic accept;

  assign accept = s_axis_tvalid & s_axis_tready;

  owtr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  owtr_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .start_req_i       (s_axis_tdata[0]),
    .wait_conversion_i (s_axis_tdata[1]),
    .line_in_i         (s_axis_tdata[2]),
    .cfg_i             (cfg),
    .res_o             (res)
  );

  owtr_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .res_i         (res),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .ready_o       (s_axis_tready)
  );

endmodule

[rtl/owtr_checker.sv]
module owtr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // an empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // every accepted item yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // done only while busy, and temperature is zero otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> m_axis_tdata[1])
    else $error("done without busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[18:3] == 16'd0))
    else $error("temperature nonzero without done");

endmodule

bind one_wire_temperature_reader owtr_checker u_owtr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import owtr_pkg::*;

  // One bus tick as it travels on s_axis_tdata, highest bit first
  typedef struct packed {
    logic line;
    logic wt;
    logic start;
  } tick_t;

  typedef enum {WaitOff, WaitOn, WaitRandom} wait_mode_e;
  typedef enum {LineNoise, LineHigh, LineLow} line_style_e;

  // DUT ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [0] start_req, [1] wait_conversion, [2] line_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [0] line_drive, [1] busy_res, [2] done_res,
                                    // [18:3] temperature, [19] device_absent
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  one_wire_temperature_reader u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // Bus master model: configuration copy and sequencer state
  logic [15:0] tpu = 16'd12;
  logic [23:0] conv_wait = 24'd1000000;
  phase_e      bus_phase = PH_IDLE;
  logic [2:0]  byte_step = '0;
  logic [2:0]  bit_idx = '0;
  logic [7:0]  shift_reg = '0;
  logic [7:0]  low_byte = '0;
  logic [15:0] unit_cnt = '0;
  logic [31:0] delay_cnt = '0;
  logic        wait_flag = 1'b0;
  logic        absent_flag = 1'b0;

  tick_t tick_queue[$];
  res_t  expected_ticks[$];
  int    done_count = 0;
  int    mismatches = 0;
  bit    in_taken = 1'b0;

  // Idle/stall pattern, stepped through one mode at a time
  int send_pcts[4] = '{0, 80, 0, 16};
  int stall_pcts[4] = '{0, 0, 80, 16};
  int mode_left = 0;
  int mode_idx = 0;
  int send_idle = 0;
  int recv_stall = 0;

  line_style_e line_style = LineNoise;
  int          style_left = 600;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void enter_phase(phase_e p, int unsigned units);
    bus_phase = p;
    delay_cnt = units;
    unit_cnt = '0;
  endfunction

  // One tick of a unit-timed phase; true once the last unit has passed
  function automatic bit unit_elapsed();
    logic [16:0] t;
    t = (tpu == 16'd0) ? 17'd1 : {1'b0, tpu};
    unit_cnt = unit_cnt + 16'd1;
    if ({1'b0, unit_cnt} >= t) begin
      unit_cnt = '0;
      if (delay_cnt != 0) delay_cnt = delay_cnt - 1;
    end
    return delay_cnt == 0;
  endfunction

  function automatic void load_slot(logic [7:0] value, phase_e p);
    shift_reg = value;
    bit_idx = '0;
    enter_phase(p, 0);
  endfunction

  // Advance the sequencer by one tick and return the bus outputs
  function automatic res_t next_bus_tick(logic start, logic wt, logic line);
    res_t        r;
    logic [31:0] w;
    r = '0;
    r.line_drive = 1'b1;
    r.busy_res = (bus_phase != PH_IDLE);
    case (bus_phase)
      PH_IDLE: begin
        if (start) begin
          wait_flag = wt;
          byte_step = StepSkipA;
          enter_phase(PH_RST_PRE, RstPreUnits);
          r.busy_res = 1'b1;
        end
      end
      PH_RST_PRE: begin
        if (unit_elapsed()) enter_phase(PH_RST_LOW, RstLowUnits);
      end
      PH_RST_LOW: begin
        r.line_drive = 1'b0;
        if (unit_elapsed()) enter_phase(PH_RST_WAIT, RstWaitUnits);
      end
      PH_RST_WAIT: begin
        if (unit_elapsed()) begin
          absent_flag = line;
          enter_phase(PH_RST_POST, RstPostUnits);
        end
      end
      PH_RST_POST: begin
        if (unit_elapsed()) load_slot(CmdSkipRom, PH_WR_START);
      end
      PH_WR_START: begin
        r.line_drive = 1'b0;
        enter_phase(PH_WR_BIT, SlotUnits);
      end
      PH_WR_BIT: begin
        r.line_drive = shift_reg[0];
        if (unit_elapsed()) begin
          shift_reg = shift_reg >> 1;
          bit_idx = bit_idx + 3'd1;
          if (bit_idx == 3'd0) enter_phase(PH_WR_TAIL, SlotUnits);
          else enter_phase(PH_WR_START, 0);
        end
      end
      PH_WR_TAIL: begin
        if (unit_elapsed()) begin
          // next step of the command sequence
          case (byte_step)
            StepSkipA: begin
              byte_step = StepConvert;
              load_slot(CmdConvert, PH_WR_START);
            end
            StepConvert: begin
              byte_step = StepSkipB;
              w = 32'(conv_wait) & 32'((64'd1 << WaitBits) - 64'd1);
              if (wait_flag && w != 0) enter_phase(PH_CONV, w);
              else enter_phase(PH_RST_PRE, RstPreUnits);
            end
            StepSkipB: begin
              byte_step = StepReadCmd;
              load_slot(CmdReadPad, PH_WR_START);
            end
            StepReadCmd: begin
              byte_step = StepLowByte;
              load_slot(8'h00, PH_RD_START);
            end
            default: begin
              byte_step = StepSkipA;
              enter_phase(PH_IDLE, 0);
            end
          endcase
        end
      end
      PH_RD_START: begin
        r.line_drive = 1'b0;
        enter_phase(PH_RD_SAMPLE, 0);
      end
      PH_RD_SAMPLE: begin
        shift_reg = {line, shift_reg[7:1]};
        enter_phase(PH_RD_GAP, SlotUnits);
      end
      PH_RD_GAP: begin
        if (unit_elapsed()) begin
          bit_idx = bit_idx + 3'd1;
          if (bit_idx != 3'd0) begin
            enter_phase(PH_RD_START, 0);
          end else if (byte_step == StepLowByte) begin
            low_byte = shift_reg;
            byte_step = StepHighByte;
            load_slot(8'h00, PH_RD_START);
          end else begin
            r.done_res = 1'b1;
            r.temperature = {shift_reg, low_byte};
            byte_step = StepSkipA;
            enter_phase(PH_IDLE, 0);
          end
        end
      end
      PH_CONV: begin
        if (delay_cnt != 0) delay_cnt = delay_cnt - 1;
        if (delay_cnt == 0) enter_phase(PH_RST_PRE, RstPreUnits);
      end
      default: begin
        byte_step = StepSkipA;
        enter_phase(PH_IDLE, 0);
      end
    endcase
    r.device_absent = absent_flag;
    return r;
  endfunction

  // Random tick; the bus level follows a style that changes now and then
  function automatic tick_t gen_tick(logic may_start, wait_mode_e wm);
    tick_t t;
    int    pick;
    if (style_left == 0) begin
      style_left = 600;
      pick = $urandom_range(0, 9);
      line_style = (pick < 6) ? LineNoise : (pick < 8) ? LineHigh : LineLow;
    end
    style_left--;
    t.start = may_start && ($urandom_range(0, 15) == 0);
    t.wt = (wm == WaitRandom) ? 1'($urandom_range(0, 1)) : (wm == WaitOn);
    case (line_style)
      LineHigh: t.line = 1'b1;
      LineLow:  t.line = 1'b0;
      default:  t.line = 1'($urandom_range(0, 1));
    endcase
    return t;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Register write over the APB port, mirrored into the model
  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == RegTicksPerUnit) tpu = value[15:0];
    else conv_wait = value[23:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || s_axis_tvalid || expected_ticks.size() != 0)
      @(posedge clk_i);
  endtask

  // Feed quiet ticks until the transaction in flight has ended and all results are in
  task automatic drain_to_idle();
    while (!(bus_phase == PH_IDLE && tick_queue.size() == 0 && !s_axis_tvalid &&
             expected_ticks.size() == 0)) begin
      if (bus_phase != PH_IDLE && tick_queue.size() < 4)
        tick_queue.push_back(gen_tick(1'b0, WaitRandom));
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  // One start per transaction, then quiet ticks until it is done
  task automatic run_transactions(int count, wait_mode_e wm);
    int    target;
    tick_t t;
    for (int n = 0; n < count; n++) begin
      target = done_count + 1;
      t = gen_tick(1'b0, wm);
      t.start = 1'b1;
      tick_queue.push_back(t);
      while (done_count < target) begin
        if (tick_queue.size() < 16) tick_queue.push_back(gen_tick(1'b0, wm));
        else @(posedge clk_i);
      end
      drain_to_idle();
    end
  endtask

  // Driver and receiver, both changing at the falling edge
  always @(negedge clk_i) begin
    int m;
    if (mode_left == 0) begin
      mode_left = 250;
      m = mode_idx;
      mode_idx = (mode_idx + 1) % 4;
      send_idle = send_pcts[m];
      recv_stall = stall_pcts[m];
    end
    mode_left--;
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
      if (!s_axis_tvalid || in_taken) begin
        if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          s_axis_tdata <= {5'b0, tick_queue.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Predict on each accepted tick, check each accepted result
  always @(posedge clk_i) begin
    res_t  want;
    res_t  got;
    tick_t t;
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        t = tick_t'(s_axis_tdata[2:0]);
        want = next_bus_tick(t.start, t.wt, t.line);
        expected_ticks.push_back(want);
        if (want.done_res) done_count++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[19:0]);
        if (expected_ticks.size() == 0) begin
          mismatches++;
          $display("%0t: result with no expected item, expected none, got %h",
                   $time, m_axis_tdata);
        end else begin
          want = expected_ticks.pop_front();
          check_field("line_drive", 16'(want.line_drive), 16'(got.line_drive));
          check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
          check_field("done_res", 16'(want.done_res), 16'(got.done_res));
          check_field("temperature", want.temperature, got.temperature);
          check_field("device_absent", 16'(want.device_absent), 16'(got.device_absent));
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle ticks with every wait/line combination
    for (int i = 0; i < 4; i++) tick_queue.push_back(tick_t'({i[1:0], 1'b0}));
    wait_drained();

    // fastest timing, zero wait skips the conversion phase even with the flag set;
    // starts while busy are ignored
    write_reg(RegTicksPerUnit, 32'd1);
    write_reg(RegConvWait, 32'd0);
    tick_queue.push_back(tick_t'(3'b011));
    for (int i = 0; i < 4; i++) tick_queue.push_back(tick_t'({i[1:0], 1'b1}));
    run_transactions(1, WaitRandom);

    // zero ticks per unit behaves like one, short conversion wait
    write_reg(RegTicksPerUnit, 32'd0);
    write_reg(RegConvWait, 32'($urandom_range(1, 40)));
    run_transactions(1, WaitOn);

    // largest settings: only the start of a very slow transaction fits
    write_reg(RegTicksPerUnit, 32'd65535);
    write_reg(RegConvWait, 32'h00FF_FFFF);
    tick_queue.push_back(tick_t'({1'($urandom_range(0, 1)), 2'b11}));
    for (int n = 0; n < 100; n++) begin
      while (tick_queue.size() >= 16) @(posedge clk_i);
      tick_queue.push_back(gen_tick(1'b1, WaitRandom));
    end

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && expected_ticks.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/owtr_pkg.sv
rtl/owtr_cfg.sv
rtl/owtr_core.sv
rtl/owtr_out.sv
rtl/one_wire_temperature_reader.sv
rtl/owtr_checker.sv
verif/tb.sv
